FILE: rtl/axis_angle_rotation_matrix_assert.svh
// Assertion macros for the rotation matrix block.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AARM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AARM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/aarm_pkg.sv
package aarm_pkg;

  // Default widths and iteration counts.
  localparam int FRAC_BITS_DEF = 14;
  localparam int TRIG_ITER_DEF = 16;
  localparam int AXIS_W        = 16;
  localparam int ANGLE_W       = 32;
  localparam int OUT_W         = 16;
  localparam int OUT_FRAC      = 14;

  // Degrees (Q16.16, one quadrant) to Q30 radians with pi = 3.1415926:
  // z = ZK*e + floor((ZR*e + ZH) / ZD), which equals the rounded product.
  localparam int unsigned ZK = 285;
  localparam int unsigned ZR = 6713014;
  localparam int unsigned ZD = 7031250;
  localparam int unsigned ZH = 3515625;
  localparam int          ZB = 23;

  // Bias that keeps the coarse angle count positive; a multiple of 45.
  localparam int unsigned ANG_BIAS  = 4140;
  // Reciprocal of 45 scaled by 2^20, rounded up.
  localparam int unsigned RECIP45   = 23302;

  // Square root of a 64-bit word takes one result bit per step.
  localparam int SQRT_STEPS = 32;

  // Arctangent of 2^-i in Q30 radians.
  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  // Partial state of a bit-by-bit square root.
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sq_t;

  // One step of the square root; step j tests bit 2^(62-2j).
  function automatic sq_t isqrt_step(sq_t a, int unsigned j);
    logic [63:0] b;
    logic [63:0] tr;
    sq_t r;
    b  = 64'd1 << (62 - 2 * j);
    tr = a.root + b;
    if (a.rem >= tr) begin
      r.rem  = a.rem - tr;
      r.root = (a.root >> 1) + b;
    end else begin
      r.rem  = a.rem;
      r.root = a.root >> 1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/axis_angle_rotation_matrix.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-------------------------------------
// in       | in_valid_i / in_ready_o   | axis_x_i, axis_y_i, axis_z_i, angle_deg_i
// out      | out_valid_o / out_ready_i | m00_o .. m22_o, zero_axis_o
//
// One request enters per cycle while in_ready_o is high; the pipeline length is set by
// the chain of the angle divider, the CORDIC stages, the gain square root and the
// cos/sin divider, one bit or one rotation per stage.
// Every stage has its own valid bit and loads when it is empty or the stage after it
// moves, so bubbles close up and a stall at the output holds every request in place.
// Reset clears the valid bits only; no clearing pass is needed.
`include "axis_angle_rotation_matrix_assert.svh"

module axis_angle_rotation_matrix
  import aarm_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [AXIS_W-1:0]  axis_x_i,
  input  logic signed [AXIS_W-1:0]  axis_y_i,
  input  logic signed [AXIS_W-1:0]  axis_z_i,
  input  logic signed [ANGLE_W-1:0] angle_deg_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [OUT_W-1:0]   m00_o,
  output logic signed [OUT_W-1:0]   m01_o,
  output logic signed [OUT_W-1:0]   m02_o,
  output logic signed [OUT_W-1:0]   m10_o,
  output logic signed [OUT_W-1:0]   m11_o,
  output logic signed [OUT_W-1:0]   m12_o,
  output logic signed [OUT_W-1:0]   m20_o,
  output logic signed [OUT_W-1:0]   m21_o,
  output logic signed [OUT_W-1:0]   m22_o,
  output logic                      zero_axis_o
);

  // Widths that follow from the fraction size.
  localparam int QB = FRAC_BITS + 1;       // quotient bits of the rounding dividers
  localparam int NW = FRAC_BITS + 32;      // dividend width of those dividers
  localparam int CW = FRAC_BITS + 3;       // cos, sin, axis and 1-cos
  localparam int MW = FRAC_BITS + 4;       // matrix entry before output scaling
  localparam int WW = MW + 14;             // room for the output shift
  localparam int NIT = (TRIG_ITERATIONS < 32) ? TRIG_ITERATIONS : 32;
  localparam int OSH = FRAC_BITS - OUT_FRAC;
  localparam int OSH_R = (OSH > 0) ? OSH : 1;
  localparam int OSH_L = (OSH < 0) ? -OSH : 0;

  // Stage map.
  localparam int K_PRE = 1;
  localparam int AS0 = 2;
  localparam int AS1 = AS0 + SQRT_STEPS - 1;
  localparam int K_NI = AS1 + 1;
  localparam int ND0 = K_NI + 1;
  localparam int ND1 = K_NI + QB;
  localparam int ZD0 = 2;
  localparam int ZD1 = ZD0 + ZB - 1;
  localparam int K_ZI = ZD1 + 1;
  localparam int CR0 = K_ZI + 1;
  localparam int CR1 = CR0 + NIT - 1;
  localparam int K_SQ = CR1 + 1;
  localparam int K_SS = K_SQ + 1;
  localparam int TS0 = K_SS + 1;
  localparam int TS1 = K_SS + SQRT_STEPS;
  localparam int K_CI = TS1 + 1;
  localparam int CD0 = K_CI + 1;
  localparam int CD1 = K_CI + QB;
  localparam int K_CS = CD1 + 1;
  localparam int K_P1 = K_CS + 1;
  localparam int K_P2 = K_P1 + 1;
  localparam int K_O = K_P2 + 1;
  localparam int NST = K_O + 1;

  localparam logic signed [CW-1:0]   ONE_S = CW'(1) <<< FRAC_BITS;
  localparam logic [QB-1:0]          ONE_Q = QB'(1) << FRAC_BITS;
  localparam logic signed [2*CW-1:0] RND_P = (2*CW)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [WW-1:0]   RND_O = WW'(1) <<< (OSH_R - 1);
  localparam logic signed [WW-1:0]   SMAX = WW'(32767);
  localparam logic signed [WW-1:0]   SMIN = -WW'(32768);
  localparam logic signed [OUT_W-1:0] OUT_ONE = OUT_W'(1) <<< OUT_FRAC;

  // Everything a request carries down the pipeline.
  typedef struct {
    logic                    zero;
    logic signed [15:0]      v0, v1, v2;
    logic [31:0]             sq0, sq1, sq2;
    logic [13:0]             u;
    logic [7:0]              qa;
    logic [18:0]             lo;
    logic [1:0]              quad;
    logic [22:0]             e;
    sq_t                     ar;
    logic [46:0]             zp;
    logic [22:0]             zq;
    logic [31:0]             zb;
    logic signed [33:0]      cx, cy;
    logic signed [31:0]      cz;
    logic [63:0]             xx, yy;
    sq_t                     tr;
    logic [31:0]             nden, tden;
    logic [NW-1:0]           nn0, nn1, nn2, cn, sn;
    logic [QB-1:0]           nq0, nq1, nq2, cq, sq;
    logic                    ns0, ns1, ns2, cneg, sneg;
    logic signed [CW-1:0]    c, s, n0, n1, n2, t;
    logic signed [CW-1:0]    p00, p11, p22, p01, p02, p12, sk0, sk1, sk2;
    logic signed [MW-1:0]    m0, m1, m2, m3, m4, m5, m6, m7, m8;
    logic signed [OUT_W-1:0] o0, o1, o2, o3, o4, o5, o6, o7, o8;
  } item_t;

  // Product of two Q(FRAC_BITS) values, rounded half up.
  function automatic logic signed [CW-1:0] mulq(logic signed [CW-1:0] a,
                                                logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] pr;
    pr = a * b + RND_P;
    return CW'(pr >>> FRAC_BITS);
  endfunction

  // Restoring divider step for quotient bit i.
  function automatic logic [NW:0] div_step(logic [NW-1:0] num, logic [31:0] den,
                                           int unsigned i);
    logic [NW-1:0] shd;
    shd = NW'(den) << i;
    if (num >= shd) begin
      return {1'b1, num - shd};
    end
    return {1'b0, num};
  endfunction

  // Quotient magnitude to a signed value, clamped to one.
  function automatic logic signed [CW-1:0] finish_q(logic [QB-1:0] q, logic neg);
    logic signed [CW-1:0] v;
    v = (q > ONE_Q) ? ONE_S : signed'(CW'(q));
    return neg ? -v : v;
  endfunction

  // Matrix entry to Q2.14 with saturation.
  function automatic logic signed [OUT_W-1:0] to_out(logic signed [MW-1:0] m);
    logic signed [WW-1:0] w;
    w = WW'(m);
    if (OSH > 0) begin
      w = (w + RND_O) >>> OSH_R;
    end else begin
      w = w <<< OSH_L;
    end
    if (w > SMAX) begin
      w = SMAX;
    end else if (w < SMIN) begin
      w = SMIN;
    end
    return OUT_W'(w);
  endfunction

  item_t           pipe_q [NST];
  logic [NST-1:0]  pv_q;
  logic [NST-1:0]  adv;

  // A stage loads when it is empty or its content moves on.
  assign adv[NST-1] = !pv_q[NST-1] || out_ready_i;
  for (genvar k = 0; k < NST - 1; k++) begin : g_adv
    assign adv[k] = !pv_q[k] || adv[k+1];
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      for (int k = NST - 1; k > 0; k--) begin
        if (adv[k]) begin
          pv_q[k] <= pv_q[k-1];
        end
      end
      if (adv[0]) begin
        pv_q[0] <= in_valid_i;
      end
    end
  end

  // First stage: axis squares and coarse angle reduction.
  item_t nx0;
  always_comb begin
    logic signed [12:0] sc;
    logic signed [31:0] p0, p1, p2;
    nx0 = '{default: '0};
    nx0.v0 = axis_x_i;
    nx0.v1 = axis_y_i;
    nx0.v2 = axis_z_i;
    p0 = axis_x_i * axis_x_i;
    p1 = axis_y_i * axis_y_i;
    p2 = axis_z_i * axis_z_i;
    nx0.sq0 = 32'(p0);
    nx0.sq1 = 32'(p1);
    nx0.sq2 = 32'(p2);
    sc = angle_deg_i[31:19];
    nx0.u  = 14'(sc) + 14'(ANG_BIAS);
    nx0.qa = 8'((28'(nx0.u) * 28'(RECIP45)) >> 20);
    nx0.lo = angle_deg_i[18:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      pipe_q[0] <= nx0;
    end
  end

  for (genvar k = 1; k < NST; k++) begin : g_st
    localparam int AJ = (k >= AS0 && k <= AS1) ? k - AS0 : 0;
    localparam int NI = (k >= ND0 && k <= ND1) ? QB - 1 - (k - ND0) : 0;
    localparam int ZI = (k >= ZD0 && k <= ZD1) ? ZB - 1 - (k - ZD0) : 0;
    localparam int CI = (k >= CR0 && k <= CR1) ? k - CR0 : 0;
    localparam int TJ = (k >= TS0 && k <= TS1) ? k - TS0 : 0;
    localparam int DI = (k >= CD0 && k <= CD1) ? QB - 1 - (k - CD0) : 0;
    item_t nx;

    always_comb begin
      logic [31:0]        l2;
      logic [15:0]        rw;
      logic [7:0]         h;
      logic [7:0]         hm;
      logic [46:0]        zs;
      logic [NW:0]        dr;
      logic signed [33:0] dx, dy;
      logic signed [31:0] xs, ys;
      logic signed [63:0] px, py;
      logic [31:0]        mag;
      logic [31:0]        ax;
      logic signed [16:0] w0, w1, w2;
      logic signed [CW-1:0] c0, s0;
      logic signed [CW-1:0] tp00, tp11, tp22, tp01, tp02, tp12;
      nx = pipe_q[k-1];

      // Axis length and angle quadrant.
      if (k == K_PRE) begin
        l2 = nx.sq0 + nx.sq1 + nx.sq2;
        nx.zero = (l2 == 32'd0);
        nx.ar.rem = {2'b00, l2, 30'd0};
        nx.ar.root = '0;
        rw = 16'(nx.u) - 16'(nx.qa) * 16'd45;
        if (rw[15]) begin
          rw = rw + 16'd45;
        end
        h = {rw[5:0], nx.lo[18:17]};
        if (h >= 8'd135) begin
          nx.quad = 2'd3;
        end else if (h >= 8'd90) begin
          nx.quad = 2'd2;
        end else if (h >= 8'd45) begin
          nx.quad = 2'd1;
        end else begin
          nx.quad = 2'd0;
        end
        hm = h - 8'(nx.quad) * 8'd45;
        nx.e = {hm[5:0], nx.lo[16:0]};
        nx.zp = 47'(nx.e) * 47'(ZR) + 47'(ZH);
        nx.zb = 32'(nx.e) * 32'(ZK);
        nx.zq = '0;
      end

      // Square root of the scaled axis length, one bit per stage.
      if (k >= AS0 && k <= AS1) begin
        nx.ar = isqrt_step(nx.ar, AJ);
      end

      // Set up the three axis dividers.
      if (k == K_NI) begin
        nx.nden = nx.ar.root[31:0];
        w0 = 17'(nx.v0);
        w1 = 17'(nx.v1);
        w2 = 17'(nx.v2);
        nx.ns0 = w0[16];
        nx.ns1 = w1[16];
        nx.ns2 = w2[16];
        w0 = w0[16] ? -w0 : w0;
        w1 = w1[16] ? -w1 : w1;
        w2 = w2[16] ? -w2 : w2;
        nx.nn0 = (NW'(w0) << (FRAC_BITS + 15)) + NW'(nx.nden >> 1);
        nx.nn1 = (NW'(w1) << (FRAC_BITS + 15)) + NW'(nx.nden >> 1);
        nx.nn2 = (NW'(w2) << (FRAC_BITS + 15)) + NW'(nx.nden >> 1);
        nx.nq0 = '0;
        nx.nq1 = '0;
        nx.nq2 = '0;
      end

      // Axis divider steps.
      if (k >= ND0 && k <= ND1) begin
        dr = div_step(nx.nn0, nx.nden, NI);
        nx.nn0 = dr[NW-1:0];
        nx.nq0[NI] = dr[NW];
        dr = div_step(nx.nn1, nx.nden, NI);
        nx.nn1 = dr[NW-1:0];
        nx.nq1[NI] = dr[NW];
        dr = div_step(nx.nn2, nx.nden, NI);
        nx.nn2 = dr[NW-1:0];
        nx.nq2[NI] = dr[NW];
      end

      // Fractional part of the degree to radian scaling, one bit per stage.
      if (k >= ZD0 && k <= ZD1) begin
        zs = 47'(ZD) << ZI;
        if (nx.zp >= zs) begin
          nx.zp = nx.zp - zs;
          nx.zq[ZI] = 1'b1;
        end
      end

      // CORDIC start vector.
      if (k == K_ZI) begin
        nx.cz = signed'(nx.zb + 32'(nx.zq));
        nx.cx = 34'sh0_4000_0000;
        nx.cy = '0;
      end

      // One CORDIC rotation per stage.
      if (k >= CR0 && k <= CR1) begin
        dx = nx.cy >>> CI;
        dy = nx.cx >>> CI;
        if (!nx.cz[31]) begin
          nx.cx = nx.cx - dx;
          nx.cy = nx.cy + dy;
          nx.cz = nx.cz - signed'(32'(ATAN_Q30[CI]));
        end else begin
          nx.cx = nx.cx + dx;
          nx.cy = nx.cy - dy;
          nx.cz = nx.cz + signed'(32'(ATAN_Q30[CI]));
        end
      end

      // Squares of the rotated vector.
      if (k == K_SQ) begin
        xs = nx.cx[31:0];
        ys = nx.cy[31:0];
        px = xs * xs;
        py = ys * ys;
        nx.xx = px;
        nx.yy = py;
      end

      if (k == K_SS) begin
        nx.tr.rem = nx.xx + nx.yy;
        nx.tr.root = '0;
      end

      // Square root of the CORDIC gain, one bit per stage.
      if (k >= TS0 && k <= TS1) begin
        nx.tr = isqrt_step(nx.tr, TJ);
      end

      // Set up the cos and sin dividers.
      if (k == K_CI) begin
        mag = nx.tr.root[31:0];
        if (mag == 32'd0) begin
          mag = 32'd1;
        end
        nx.tden = mag;
        nx.cneg = nx.cx[33];
        nx.sneg = nx.cy[33];
        ax = nx.cx[33] ? 32'(-nx.cx) : nx.cx[31:0];
        nx.cn = (NW'(ax) << FRAC_BITS) + NW'(mag >> 1);
        ax = nx.cy[33] ? 32'(-nx.cy) : nx.cy[31:0];
        nx.sn = (NW'(ax) << FRAC_BITS) + NW'(mag >> 1);
        nx.cq = '0;
        nx.sq = '0;
      end

      if (k >= CD0 && k <= CD1) begin
        dr = div_step(nx.cn, nx.tden, DI);
        nx.cn = dr[NW-1:0];
        nx.cq[DI] = dr[NW];
        dr = div_step(nx.sn, nx.tden, DI);
        nx.sn = dr[NW-1:0];
        nx.sq[DI] = dr[NW];
      end

      // Signs, clamping and the quadrant.
      if (k == K_CS) begin
        c0 = finish_q(nx.cq, nx.cneg);
        s0 = finish_q(nx.sq, nx.sneg);
        case (nx.quad)
          2'd0: begin
            nx.c = c0;
            nx.s = s0;
          end
          2'd1: begin
            nx.c = -s0;
            nx.s = c0;
          end
          2'd2: begin
            nx.c = -c0;
            nx.s = -s0;
          end
          default: begin
            nx.c = s0;
            nx.s = -c0;
          end
        endcase
        nx.n0 = finish_q(nx.nq0, nx.ns0);
        nx.n1 = finish_q(nx.nq1, nx.ns1);
        nx.n2 = finish_q(nx.nq2, nx.ns2);
      end

      // Outer products of the axis and the sine terms.
      if (k == K_P1) begin
        nx.t = ONE_S - nx.c;
        nx.p00 = mulq(nx.n0, nx.n0);
        nx.p11 = mulq(nx.n1, nx.n1);
        nx.p22 = mulq(nx.n2, nx.n2);
        nx.p01 = mulq(nx.n0, nx.n1);
        nx.p02 = mulq(nx.n0, nx.n2);
        nx.p12 = mulq(nx.n1, nx.n2);
        nx.sk0 = mulq(nx.s, nx.n0);
        nx.sk1 = mulq(nx.s, nx.n1);
        nx.sk2 = mulq(nx.s, nx.n2);
      end

      // Matrix entries.
      if (k == K_P2) begin
        tp00 = mulq(nx.t, nx.p00);
        tp11 = mulq(nx.t, nx.p11);
        tp22 = mulq(nx.t, nx.p22);
        tp01 = mulq(nx.t, nx.p01);
        tp02 = mulq(nx.t, nx.p02);
        tp12 = mulq(nx.t, nx.p12);
        nx.m0 = MW'(tp00) + MW'(nx.c);
        nx.m1 = MW'(tp01) - MW'(nx.sk2);
        nx.m2 = MW'(tp02) + MW'(nx.sk1);
        nx.m3 = MW'(tp01) + MW'(nx.sk2);
        nx.m4 = MW'(tp11) + MW'(nx.c);
        nx.m5 = MW'(tp12) - MW'(nx.sk0);
        nx.m6 = MW'(tp02) - MW'(nx.sk1);
        nx.m7 = MW'(tp12) + MW'(nx.sk0);
        nx.m8 = MW'(tp22) + MW'(nx.c);
      end

      // Output scaling; a zero axis gives the identity.
      if (k == K_O) begin
        if (nx.zero) begin
          nx.o0 = OUT_ONE;
          nx.o1 = '0;
          nx.o2 = '0;
          nx.o3 = '0;
          nx.o4 = OUT_ONE;
          nx.o5 = '0;
          nx.o6 = '0;
          nx.o7 = '0;
          nx.o8 = OUT_ONE;
        end else begin
          nx.o0 = to_out(nx.m0);
          nx.o1 = to_out(nx.m1);
          nx.o2 = to_out(nx.m2);
          nx.o3 = to_out(nx.m3);
          nx.o4 = to_out(nx.m4);
          nx.o5 = to_out(nx.m5);
          nx.o6 = to_out(nx.m6);
          nx.o7 = to_out(nx.m7);
          nx.o8 = to_out(nx.m8);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        pipe_q[k] <= nx;
      end
    end
  end

  // Ports.
  assign in_ready_o  = adv[0];
  assign out_valid_o = pv_q[NST-1];
  assign m00_o = pipe_q[NST-1].o0;
  assign m01_o = pipe_q[NST-1].o1;
  assign m02_o = pipe_q[NST-1].o2;
  assign m10_o = pipe_q[NST-1].o3;
  assign m11_o = pipe_q[NST-1].o4;
  assign m12_o = pipe_q[NST-1].o5;
  assign m20_o = pipe_q[NST-1].o6;
  assign m21_o = pipe_q[NST-1].o7;
  assign m22_o = pipe_q[NST-1].o8;
  assign zero_axis_o = pipe_q[NST-1].zero;

  // An empty output stage never blocks the input.
  `AARM_ASSERT_IMP(a_ready_when_empty, !out_valid_o, in_ready_o, "input blocked while output empty")
  // The angle scaling divider leaves a remainder below its divisor.
  `AARM_ASSERT_IMP(a_zdiv_rem, pv_q[ZD1], pipe_q[ZD1].zp < 47'(ZD), "angle divider remainder too large")
  // Normalized axis components never exceed one.
  `AARM_ASSERT_IMP(a_axis_unit, pv_q[ND1] && !pipe_q[ND1].zero, pipe_q[ND1].nq0 <= ONE_Q && pipe_q[ND1].nq1 <= ONE_Q && pipe_q[ND1].nq2 <= ONE_Q, "axis quotient above one")
  // A zero axis always comes out as the identity.
  `AARM_ASSERT_IMP(a_zero_identity, out_valid_o && zero_axis_o, m00_o == OUT_ONE && m11_o == OUT_ONE && m22_o == OUT_ONE && m01_o == '0 && m12_o == '0 && m20_o == '0, "zero axis without identity")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import aarm_pkg::*;

  // One rotation request and the matrix it produces.
  typedef struct {
    logic signed [15:0] ax, ay, az;
    logic signed [31:0] ang;
  } rot_req_t;

  typedef struct {
    logic signed [15:0] m [9];
    logic               zero;
  } rot_mat_t;

  localparam int FB    = FRAC_BITS_DEF;
  localparam int ITERS = TRIG_ITER_DEF;
  localparam int LATENCY = 66 + ITERS + FB;
  localparam int STALL_LIMIT = 20000;

  // Expected matrices in arrival order, with the Rodrigues predictor.
  class rot_scoreboard;
    rot_mat_t pending[$];
    int       errors;

    function longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    function longint round_shr(longint v, int s);
      if (s == 0) return v;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Divide rounding half away from zero; den is positive.
    function longint div_away(longint num, logic [63:0] den);
      logic [63:0] mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint clamp_one(longint v);
      longint one;
      one = 64'sd1 <<< FB;
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
    endfunction

    function longint mul_fx(longint a, longint b);
      return round_shr(a * b, FB);
    endfunction

    function logic signed [15:0] to_q14(longint v);
      longint w;
      w = (FB >= OUT_FRAC) ? round_shr(v, FB - OUT_FRAC) : v <<< (OUT_FRAC - FB);
      if (w > 32767) w = 32767;
      if (w < -32768) w = -32768;
      return w[15:0];
    endfunction

    // CORDIC cos and sin of a first-quadrant angle in Q16.16 degrees.
    function void cordic_cos_sin(longint e, output longint c, output longint s);
      logic [63:0] num, mag;
      longint z, x, y, dx, dy;
      num = (e * 64'd31415926) << 14;
      z = (num + 64'd900000000) / 64'd1800000000;
      x = 64'sd1 <<< 30;
      y = 0;
      for (int i = 0; i < ITERS && i < 32; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
        end
      end
      mag = int_sqrt(x * x + y * y);
      if (mag == 0) mag = 1;
      c = clamp_one(div_away(x <<< FB, mag));
      s = clamp_one(div_away(y <<< FB, mag));
    endfunction

    function rot_mat_t rodrigues(rot_req_t rq);
      rot_mat_t r;
      longint v[3], n[3], mm[9];
      longint r360, e, c0, s0, c, s, t;
      logic [63:0] l2, nrm;
      int q;
      v[0] = rq.ax; v[1] = rq.ay; v[2] = rq.az;
      l2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      if (l2 == 0) begin
        for (int i = 0; i < 9; i++) r.m[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
        r.zero = 1'b1;
        return r;
      end
      nrm = int_sqrt(l2 << 30);
      for (int i = 0; i < 3; i++) n[i] = clamp_one(div_away(v[i] <<< (FB + 15), nrm));
      r360 = longint'(rq.ang) % (64'sd360 <<< 16);
      if (r360 < 0) r360 += 64'sd360 <<< 16;
      q = int'(r360 / (64'sd90 <<< 16));
      e = r360 - q * (64'sd90 <<< 16);
      cordic_cos_sin(e, c0, s0);
      case (q)
        0: begin c = c0; s = s0; end
        1: begin c = -s0; s = c0; end
        2: begin c = -c0; s = -s0; end
        default: begin c = s0; s = -c0; end
      endcase
      t = (64'sd1 <<< FB) - c;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          mm[i * 3 + j] = mul_fx(t, mul_fx(n[i], n[j])) + ((i == j) ? c : 0);
      mm[1] -= mul_fx(s, n[2]);
      mm[2] += mul_fx(s, n[1]);
      mm[3] += mul_fx(s, n[2]);
      mm[5] -= mul_fx(s, n[0]);
      mm[6] -= mul_fx(s, n[1]);
      mm[7] += mul_fx(s, n[0]);
      for (int i = 0; i < 9; i++) r.m[i] = to_q14(mm[i]);
      r.zero = 1'b0;
      return r;
    endfunction

    function void note_request(rot_req_t rq);
      pending.push_back(rodrigues(rq));
    endfunction

    function void check_matrix(rot_mat_t got);
      rot_mat_t exp_m;
      if (pending.size() == 0) begin
        $display("%0t: unexpected matrix, zero flag %0b", $time, got.zero);
        errors++;
        return;
      end
      exp_m = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (got.m[i] !== exp_m.m[i]) begin
          $display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                   exp_m.m[i], got.m[i]);
          errors++;
        end
      if (got.zero !== exp_m.zero) begin
        $display("%0t: zero_axis expected %0b actual %0b", $time, exp_m.zero, got.zero);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, zero_axis_o;
  logic signed [15:0] axis_x_i = '0, axis_y_i = '0, axis_z_i = '0;
  logic signed [31:0] angle_deg_i = '0;
  logic signed [15:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;

  rot_scoreboard sb = new();
  int send_idle_pct = 38;
  int recv_idle_pct = 83;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  axis_angle_rotation_matrix dut (.*);

  // Receiver: random ready at the falling edge, or held low during a hold-off.
  always @(negedge clk_i)
    out_ready_i <= rst_ni && !hold_off && ($urandom_range(99) >= recv_idle_pct);

  // Check results and track progress at the rising edge.
  always @(posedge clk_i) begin
    rot_mat_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.m = '{m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o};
        got.zero = zero_axis_o;
        sb.check_matrix(got);
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one request and hold it until accepted; valid drops only while idling.
  task automatic send_request(rot_req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    axis_x_i <= rq.ax;
    axis_y_i <= rq.ay;
    axis_z_i <= rq.az;
    angle_deg_i <= rq.ang;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(rq);
    @(negedge clk_i);
  endtask

  // Stop offering requests.
  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_axis(int x, int y, int z, int a);
    rot_req_t rq;
    rq.ax = 16'(x); rq.ay = 16'(y); rq.az = 16'(z); rq.ang = a;
    send_request(rq);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      3: return 16'($urandom_range(64) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic signed [31:0] rand_angle();
    case ($urandom_range(4))
      0: return $urandom_range(4) * (90 << 16);
      1: return $signed($urandom_range(720)) - 360 <<< 16;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_batch(int count);
    rot_req_t rq;
    for (int i = 0; i < count; i++) begin
      rq.ax = rand_comp(); rq.ay = rand_comp(); rq.az = rand_comp();
      rq.ang = rand_angle();
      send_request(rq);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero axis, axis extremes, quadrant boundaries, wrapped angles.
    send_axis(0, 0, 0, 30 << 16);
    send_axis(0, 0, 0, 32'sh80000000);
    send_axis(16384, 0, 0, 90 << 16);
    send_axis(0, 16384, 0, 180 << 16);
    send_axis(0, 0, 16384, 270 << 16);
    send_axis(0, 0, 16384, 0);
    send_axis(0, 0, 16384, 360 << 16);
    send_axis(-32768, -32768, -32768, 45 << 16);
    send_axis(32767, 32767, 32767, -(45 << 16));
    send_axis(32767, -32768, 1, 32'sh7fffffff);
    send_axis(1, 0, 0, 32'sh80000000);
    send_axis(0, -1, 0, -1);
    send_axis(1, 1, 1, (90 << 16) - 1);
    send_axis(-1, 0, 0, (720 << 16) + 1);
    send_axis(5, -7, 3, -(1000 << 16));
    send_axis(16384, 16384, 0, 1);
    send_axis(0, 32767, -32768, 1 << 15);

    random_batch(130);

    // Long receiver hold-off while requests keep coming, then a full drain.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      random_batch(120);
    join
    idle_input();
    wait_drained();

    send_idle_pct = 83;
    recv_idle_pct = 38;
    random_batch(70);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_batch(80);
    idle_input();

    wait_drained();
    repeat (LATENCY + 20) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
